@@ rtl/tofc_pkg.sv @@
// Package for the time-of-flight depth corrector: word types, register
// indexes, reset values and pipeline constants. Depends on nothing.
package tofc_pkg;

	localparam int RAW_BITS_DEF   = 12;
	localparam int COORD_BITS_DEF = 10;
	localparam int FIELD_COORD_W  = 10;
	localparam int FACT_LAT       = 53;

	localparam logic [2:0] REG_GAIN      = 3'd0;
	localparam logic [2:0] REG_OFFSET    = 3'd1;
	localparam logic [2:0] REG_MAX_RANGE = 3'd2;
	localparam logic [2:0] REG_FOCAL_X   = 3'd3;
	localparam logic [2:0] REG_FOCAL_Y   = 3'd4;
	localparam logic [2:0] REG_CENTER_X  = 3'd5;
	localparam logic [2:0] REG_CENTER_Y  = 3'd6;
	localparam logic [2:0] REG_STAGE_EN  = 3'd7;

	localparam logic [15:0] GAIN_RST      = 16'd4096;
	localparam logic [15:0] MAX_RANGE_RST = 16'd16000;
	localparam logic [1:0]  STAGE_EN_RST  = 2'd3;

	typedef struct packed {
		logic [15:0] depth_in;
		logic [9:0]  pixel_col;
		logic [9:0]  pixel_row;
		logic        frame_end_in;
	} in_word_t;

	typedef struct packed {
		logic [15:0] depth_out;
		logic        clamped;
		logic        frame_end_out;
	} out_word_t;

	typedef struct packed {
		logic [15:0] focal_x;
		logic [15:0] focal_y;
	} geom_cfg_t;

	typedef struct packed {
		logic [15:0] v;
		logic        flag;
		logic        fe;
	} side_t;

endpackage

@@ rtl/tofc_factor.sv @@
// Pipelined radial-to-Z factor: products, long division and square root,
// one bit per stage. Depends on tofc_pkg.
module tofc_factor (
	input  logic                clk,
	input  logic                en,
	input  tofc_pkg::geom_cfg_t cfg,
	input  logic signed [16:0]  dx,
	input  logic signed [16:0]  dy,
	output logic [16:0]         factor
);

	logic [31:0] p_a, dx2_a, dy2_a, fx2_a, fy2_a;
	logic [63:0] p2_b, a_b, b_b;
	logic [65:0] n_c, p2_c;
	logic [65:0] r_d [0:32];
	logic [65:0] n_d [0:32];
	logic [32:0] q_d [0:32];
	logic [32:0] q_r [1:17];
	logic [16:0] f_r [1:17];
	logic signed [33:0] sqx, sqy;
	logic [66:0] r2 [1:32];
	logic        ge [1:32];
	logic [16:0] trial [1:17];
	logic [33:0] tsq [1:17];

	assign sqx = dx * dx;
	assign sqy = dy * dy;

	always_comb begin
		for (int i = 1; i <= 32; i++) begin
			r2[i] = {r_d[i-1], 1'b0};
			ge[i] = r2[i] >= {1'b0, n_d[i-1]};
		end
		for (int j = 1; j <= 17; j++) begin
			if (j == 1) begin
				trial[j] = 17'd1 << 16;
			end else begin
				trial[j] = f_r[j-1] | (17'd1 << (17 - j));
			end
			tsq[j] = trial[j] * trial[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_a   <= cfg.focal_x * cfg.focal_y;
			dx2_a <= sqx[31:0];
			dy2_a <= sqy[31:0];
			fx2_a <= cfg.focal_x * cfg.focal_x;
			fy2_a <= cfg.focal_y * cfg.focal_y;
			p2_b  <= p_a * p_a;
			a_b   <= dx2_a * fy2_a;
			b_b   <= dy2_a * fx2_a;
			p2_c  <= 66'(p2_b);
			n_c   <= 66'(p2_b) + 66'(a_b) + 66'(b_b);
			n_d[0] <= n_c;
			if (p2_c >= n_c) begin
				r_d[0] <= '0;
				q_d[0] <= 33'd1;
			end else begin
				r_d[0] <= p2_c;
				q_d[0] <= '0;
			end
			for (int i = 1; i <= 32; i++) begin
				n_d[i] <= n_d[i-1];
				q_d[i] <= {q_d[i-1][31:0], ge[i]};
				r_d[i] <= ge[i] ? 66'(r2[i] - {1'b0, n_d[i-1]}) : r2[i][65:0];
			end
			for (int j = 1; j <= 17; j++) begin
				if (j == 1) begin
					q_r[j] <= q_d[32];
					f_r[j] <= (tsq[j] <= {1'b0, q_d[32]}) ? trial[j] : 17'd0;
				end else begin
					q_r[j] <= q_r[j-1];
					f_r[j] <= (tsq[j] <= {1'b0, q_r[j-1]}) ? trial[j] : f_r[j-1];
				end
			end
		end
	end

	assign factor = (cfg.focal_x == 16'd0 || cfg.focal_y == 16'd0) ? 17'h10000 : f_r[17];

endmodule

@@ rtl/tof_depth_gain_and_radial_correction_top.sv @@
// Top level of the time-of-flight depth corrector: configuration registers,
// gain and offset stages, alignment line and final scaling.
// Depends on tofc_pkg and tofc_factor.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall   | in_word  (tofc_pkg::in_word_t)
//   out     | output    | out_valid/out_stall | out_word (tofc_pkg::out_word_t)
//   config  | input     | wr_en               | wr_index, wr_data
//
// One word is accepted per cycle unless a stalled output holds the pipeline; most
// stages belong to the factor pipeline (one division bit or one root bit per stage).
// Reset clears the valid bits and loads the register reset values.
// A stalled output word freezes the whole pipeline, so nothing is lost.
module tof_depth_gain_and_radial_correction_top #(
	parameter int RAW_BITS   = tofc_pkg::RAW_BITS_DEF,
	parameter int COORD_BITS = tofc_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tofc_pkg::in_word_t in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output tofc_pkg::out_word_t out_word,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data
);

	localparam int NS = tofc_pkg::FACT_LAT + 3;
	localparam int AL = tofc_pkg::FACT_LAT + 1;
	localparam int CW = (COORD_BITS < tofc_pkg::FIELD_COORD_W) ?
		COORD_BITS : tofc_pkg::FIELD_COORD_W;
	localparam logic [15:0] RAW_MAX = 16'((17'd1 << RAW_BITS) - 17'd1);
	localparam logic [9:0] CMASK = 10'((11'd1 << CW) - 11'd1);

	logic [15:0] gain_q, offset_q, rng_q, fx_q, fy_q, cx_q, cy_q;
	logic [1:0]  en_q;
	logic        adv;
	logic        vld [1:NS];

	logic [15:0] v_s1;
	logic        flag_s1, fe_s1;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [32:0] prod_s2;
	logic [15:0] v_s2;
	logic        flag_s2, fe_s2;
	tofc_pkg::side_t sd [3:AL];
	logic [32:0] mul_s55;
	logic [15:0] v_s55;
	logic        flag_s55, fe_s55, pass_s55;
	tofc_pkg::out_word_t out_s56;

	logic [15:0] v_in;
	logic        flag_in;
	logic [9:0]  col_m, row_m;
	logic signed [33:0] num;
	logic [21:0] vt;
	tofc_pkg::side_t s3_d;
	logic [16:0] factor;
	tofc_pkg::geom_cfg_t gcfg;
	logic [16:0] w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= tofc_pkg::GAIN_RST;
			offset_q <= '0;
			rng_q    <= tofc_pkg::MAX_RANGE_RST;
			fx_q     <= '0;
			fy_q     <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			en_q     <= tofc_pkg::STAGE_EN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				tofc_pkg::REG_GAIN:      gain_q   <= wr_data;
				tofc_pkg::REG_OFFSET:    offset_q <= wr_data;
				tofc_pkg::REG_MAX_RANGE: rng_q    <= wr_data;
				tofc_pkg::REG_FOCAL_X:   fx_q     <= wr_data;
				tofc_pkg::REG_FOCAL_Y:   fy_q     <= wr_data;
				tofc_pkg::REG_CENTER_X:  cx_q     <= wr_data;
				tofc_pkg::REG_CENTER_Y:  cy_q     <= wr_data;
				tofc_pkg::REG_STAGE_EN:  en_q     <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !(vld[NS] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) vld[i] <= 1'b0;
		end else if (adv) begin
			vld[1] <= in_valid;
			for (int i = 2; i <= NS; i++) vld[i] <= vld[i-1];
		end
	end

	always_comb begin
		col_m = in_word.pixel_col & CMASK;
		row_m = in_word.pixel_row & CMASK;
		v_in = in_word.depth_in;
		flag_in = 1'b0;
		if (en_q[0] && in_word.depth_in > RAW_MAX) begin
			v_in = RAW_MAX;
			flag_in = 1'b1;
		end

		num = 34'(prod_s2) + (34'($signed(offset_q)) <<< 12);
		vt = num[33:12];
		s3_d.v = v_s2;
		s3_d.flag = flag_s2;
		s3_d.fe = fe_s2;
		if (en_q[0]) begin
			if (num <= -34'sd4096) begin
				s3_d.v = '0;
				s3_d.flag = 1'b1;
			end else if (num < 34'sd0) begin
				s3_d.v = '0;
			end else if (vt > 22'(rng_q)) begin
				s3_d.v = rng_q;
				s3_d.flag = 1'b1;
			end else begin
				s3_d.v = vt[15:0];
			end
		end

		gcfg.focal_x = fx_q;
		gcfg.focal_y = fy_q;

		w = pass_s55 ? {1'b0, v_s55} : mul_s55[32:16];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1    <= v_in;
			flag_s1 <= flag_in;
			fe_s1   <= in_word.frame_end_in;
			dx_s1   <= $signed({1'b0, cx_q}) - $signed({3'b0, col_m, 4'b0});
			dy_s1   <= $signed({1'b0, cy_q}) - $signed({3'b0, row_m, 4'b0});

			prod_s2 <= $signed({1'b0, v_s1}) * $signed(gain_q);
			v_s2    <= v_s1;
			flag_s2 <= flag_s1;
			fe_s2   <= fe_s1;

			sd[3] <= s3_d;
			for (int i = 4; i <= AL; i++) sd[i] <= sd[i-1];

			mul_s55  <= sd[AL].v * factor;
			v_s55    <= sd[AL].v;
			flag_s55 <= sd[AL].flag;
			fe_s55   <= sd[AL].fe;
			pass_s55 <= !en_q[1] || (sd[AL].v == rng_q);

			out_s56.frame_end_out <= fe_s55;
			if (w > {1'b0, rng_q}) begin
				out_s56.depth_out <= rng_q;
				out_s56.clamped   <= 1'b1;
			end else begin
				out_s56.depth_out <= w[15:0];
				out_s56.clamped   <= flag_s55;
			end
		end
	end

	tofc_factor u_factor (
		.clk    (clk),
		.en     (adv),
		.cfg    (gcfg),
		.dx     (dx_s1),
		.dy     (dy_s1),
		.factor (factor)
	);

	assign out_valid = vld[NS];
	assign out_word  = out_s56;

endmodule

@@ dv/tb_tof_depth_gain_and_radial_correction_top.sv @@
// Testbench for the time-of-flight depth corrector: a directed table followed by
// random words under three idle patterns, checked against a predictor kept in here.
// Depends on tofc_pkg and tof_depth_gain_and_radial_correction_top.
`timescale 1ns / 1ps

module tb_tof_depth_gain_and_radial_correction_top;

	typedef struct {
		bit                   is_write;
		logic [2:0]           index;
		logic [15:0]          data;
		tofc_pkg::in_word_t   word;
		bit                   fixed;
		tofc_pkg::out_word_t  result;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tofc_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tofc_pkg::out_word_t out_word;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = tofc_pkg::REG_GAIN;
	logic [15:0] wr_data = '0;

	logic [15:0] regs [8];
	tofc_pkg::out_word_t pending_q [$];
	bit fixed_now = 1'b0;
	tofc_pkg::out_word_t fixed_word;
	int mismatches = 0;
	int send_idle = 0;
	int recv_idle = 0;
	step_t steps [$];

	tof_depth_gain_and_radial_correction_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #10 clk = ~clk;

	function automatic logic [16:0] radial_factor(logic [9:0] col, logic [9:0] row);
		longint unsigned fx, fy, p, dx2, dy2, lo, hi, mid;
		longint dx, dy;
		logic [127:0] p2, n, rhs, t;
		fx = regs[tofc_pkg::REG_FOCAL_X];
		fy = regs[tofc_pkg::REG_FOCAL_Y];
		if (fx == 0 || fy == 0) begin
			return 17'd65536;
		end
		dx = longint'(regs[tofc_pkg::REG_CENTER_X]) - longint'({col, 4'b0});
		dy = longint'(regs[tofc_pkg::REG_CENTER_Y]) - longint'({row, 4'b0});
		dx2 = dx * dx;
		dy2 = dy * dy;
		p = fx * fy;
		p2 = 128'(p) * 128'(p);
		n = p2 + 128'(dx2) * 128'(fy * fy) + 128'(dy2) * 128'(fx * fx);
		rhs = p2 << 32;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			t = 128'(mid * mid) * n;
			if (t <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return 17'(lo);
	endfunction

	function automatic tofc_pkg::out_word_t corrected_pixel(tofc_pkg::in_word_t w);
		longint unsigned v, rng;
		longint num;
		logic flag;
		tofc_pkg::out_word_t r;
		v = w.depth_in;
		rng = regs[tofc_pkg::REG_MAX_RANGE];
		flag = 1'b0;
		if (regs[tofc_pkg::REG_STAGE_EN][0]) begin
			if (v > 4095) begin
				v = 4095;
				flag = 1'b1;
			end
			num = longint'(v) * longint'($signed(regs[tofc_pkg::REG_GAIN]))
				+ longint'($signed(regs[tofc_pkg::REG_OFFSET])) * 4096;
			if (num <= -4096) begin
				v = 0;
				flag = 1'b1;
			end else if (num < 0) begin
				v = 0;
			end else begin
				v = num >>> 12;
			end
			if (v > rng) begin
				v = rng;
				flag = 1'b1;
			end
		end
		if (regs[tofc_pkg::REG_STAGE_EN][1]) begin
			if (v != rng) v = (v * radial_factor(w.pixel_col, w.pixel_row)) >> 16;
		end
		if (v > rng) begin
			v = rng;
			flag = 1'b1;
		end
		r.depth_out = v[15:0];
		r.clamped = flag;
		r.frame_end_out = w.frame_end_in;
		return r;
	endfunction

	always @(posedge clk) begin
		tofc_pkg::out_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_q.insert(pending_q.size(),
					fixed_now ? fixed_word : corrected_pixel(in_word));
			end
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected output word %p", out_word);
				end else begin
					want = pending_q.pop_front();
					if (want !== out_word) begin
						mismatches++;
						if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_word);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic wait_idle();
		while (pending_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		in_valid <= 1'b0;
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		regs[idx] = (idx == tofc_pkg::REG_STAGE_EN) ? {14'b0, value[1:0]} : value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic send_word(tofc_pkg::in_word_t w, bit fixed, tofc_pkg::out_word_t result);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		fixed_now = fixed;
		fixed_word = result;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_value(logic [15:0] lo, logic [15:0] hi);
		unique case ($urandom_range(5))
			0: return lo;
			1: return hi;
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	task automatic add_write(logic [2:0] idx, logic [15:0] value);
		step_t s;
		s = '{1'b1, idx, value, '0, 1'b0, '0};
		steps.insert(steps.size(), s);
	endtask

	task automatic add_word(logic [15:0] d, logic [9:0] c, logic [9:0] r, logic fe, bit fixed,
			logic [15:0] od, logic oc, logic ofe);
		step_t s;
		s = '{1'b0, tofc_pkg::REG_GAIN, 16'd0, '{d, c, r, fe}, fixed, '{od, oc, ofe}};
		steps.insert(steps.size(), s);
	endtask

	task automatic random_config();
		write_reg(tofc_pkg::REG_GAIN, $urandom_range(3) == 0 ? pick_value(16'h0000, 16'hFFFF)
			: 16'($urandom_range(8192, 2048)));
		write_reg(tofc_pkg::REG_OFFSET, $urandom_range(2) == 0 ? pick_value(16'h0000, 16'hFFFF)
			: 16'($urandom_range(400) - 200));
		write_reg(tofc_pkg::REG_MAX_RANGE, pick_value(16'd0, 16'hFFFF));
		write_reg(tofc_pkg::REG_FOCAL_X, $urandom_range(3) == 0 ? pick_value(16'd0, 16'hFFFF)
			: 16'($urandom_range(16'h4000, 16'h40)));
		write_reg(tofc_pkg::REG_FOCAL_Y, $urandom_range(3) == 0 ? pick_value(16'd0, 16'hFFFF)
			: 16'($urandom_range(16'h4000, 16'h40)));
		write_reg(tofc_pkg::REG_CENTER_X, pick_value(16'd0, 16'hFFFF));
		write_reg(tofc_pkg::REG_CENTER_Y, pick_value(16'd0, 16'hFFFF));
		write_reg(tofc_pkg::REG_STAGE_EN, 16'($urandom()));
	endtask

	initial begin
		#(20ns * 2_000_000);
		$display("FAIL tof_depth_gain_and_radial_correction_top");
		$finish;
	end

	initial begin
		tofc_pkg::in_word_t w;
		int waited;
		regs[tofc_pkg::REG_GAIN] = tofc_pkg::GAIN_RST;
		regs[tofc_pkg::REG_OFFSET] = '0;
		regs[tofc_pkg::REG_MAX_RANGE] = tofc_pkg::MAX_RANGE_RST;
		regs[tofc_pkg::REG_FOCAL_X] = '0;
		regs[tofc_pkg::REG_FOCAL_Y] = '0;
		regs[tofc_pkg::REG_CENTER_X] = '0;
		regs[tofc_pkg::REG_CENTER_Y] = '0;
		regs[tofc_pkg::REG_STAGE_EN] = {14'b0, tofc_pkg::STAGE_EN_RST};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: unity gain, no offset, geometry factor of one.
		add_word(16'd0, 10'd0, 10'd0, 1'b0, 1, 16'd0, 1'b0, 1'b0);
		add_word(16'd4095, 10'd1023, 10'd0, 1'b1, 1, 16'd4095, 1'b0, 1'b1);
		add_word(16'hFFFF, 10'd1023, 10'd1023, 1'b0, 1, 16'd4095, 1'b1, 1'b0);
		add_word(16'd4096, 10'd0, 10'd1023, 1'b1, 1, 16'd4095, 1'b1, 1'b1);
		add_write(tofc_pkg::REG_STAGE_EN, 16'd0);
		add_word(16'hFFFF, 10'd5, 10'd5, 1'b0, 1, 16'd16000, 1'b1, 1'b0);
		add_word(16'd16000, 10'd5, 10'd5, 1'b0, 1, 16'd16000, 1'b0, 1'b0);
		add_write(tofc_pkg::REG_STAGE_EN, 16'hFFFD);
		add_write(tofc_pkg::REG_OFFSET, 16'hFFFF);
		add_word(16'd0, 10'd0, 10'd0, 1'b0, 1, 16'd0, 1'b1, 1'b0);
		add_write(tofc_pkg::REG_OFFSET, 16'd0);
		add_write(tofc_pkg::REG_GAIN, 16'hFFFF);
		add_word(16'd1, 10'd0, 10'd0, 1'b0, 1, 16'd0, 1'b0, 1'b0);
		add_write(tofc_pkg::REG_GAIN, 16'h7FFF);
		add_write(tofc_pkg::REG_OFFSET, 16'h7FFF);
		add_write(tofc_pkg::REG_MAX_RANGE, 16'hFFFF);
		add_word(16'd4095, 10'd0, 10'd0, 1'b1, 0, '0, 1'b0, 1'b0);
		add_write(tofc_pkg::REG_GAIN, 16'h8000);
		add_write(tofc_pkg::REG_OFFSET, 16'h8000);
		add_word(16'd4095, 10'd0, 10'd0, 1'b0, 0, '0, 1'b0, 1'b0);
		add_write(tofc_pkg::REG_GAIN, tofc_pkg::GAIN_RST);
		add_write(tofc_pkg::REG_OFFSET, 16'd0);
		add_write(tofc_pkg::REG_MAX_RANGE, tofc_pkg::MAX_RANGE_RST);
		add_write(tofc_pkg::REG_STAGE_EN, 16'd2);
		add_write(tofc_pkg::REG_FOCAL_X, 16'h0100);
		add_write(tofc_pkg::REG_FOCAL_Y, 16'h0100);
		add_write(tofc_pkg::REG_CENTER_X, 16'h0200);
		add_write(tofc_pkg::REG_CENTER_Y, 16'h0200);
		add_word(16'd1000, 10'd32, 10'd32, 1'b0, 1, 16'd1000, 1'b0, 1'b0);
		add_word(16'd16000, 10'd0, 10'd0, 1'b0, 1, 16'd16000, 1'b0, 1'b0);
		add_word(16'd1000, 10'd0, 10'd1023, 1'b0, 0, '0, 1'b0, 1'b0);
		add_word(16'd65535, 10'd1023, 10'd0, 1'b1, 0, '0, 1'b0, 1'b0);
		add_write(tofc_pkg::REG_FOCAL_X, 16'hFFFF);
		add_write(tofc_pkg::REG_CENTER_X, 16'hFFFF);
		add_write(tofc_pkg::REG_CENTER_Y, 16'hFFFF);
		add_word(16'd15999, 10'd0, 10'd0, 1'b0, 0, '0, 1'b0, 1'b0);
		add_word(16'd9000, 10'd1023, 10'd1023, 1'b0, 0, '0, 1'b0, 1'b0);
		add_write(tofc_pkg::REG_FOCAL_Y, 16'd0);
		add_word(16'd12345, 10'd5, 10'd700, 1'b0, 1, 16'd12345, 1'b0, 1'b0);
		add_write(tofc_pkg::REG_MAX_RANGE, 16'd0);
		add_write(tofc_pkg::REG_FOCAL_Y, 16'h0010);
		add_word(16'd5, 10'd3, 10'd3, 1'b1, 0, '0, 1'b0, 1'b0);
		add_word(16'd0, 10'd3, 10'd3, 1'b0, 0, '0, 1'b0, 1'b0);

		foreach (steps[i]) begin
			if (steps[i].is_write) begin
				write_reg(steps[i].index, steps[i].data);
			end else begin
				send_word(steps[i].word, steps[i].fixed, steps[i].result);
			end
		end
		in_valid <= 1'b0;

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 31 : (phase == 1) ? 72 : 0;
			recv_idle = (phase == 0) ? 72 : (phase == 1) ? 31 : 0;
			for (int setting = 0; setting < 4; setting++) begin
				@(negedge clk);
				random_config();
				for (int k = 0; k < 118; k++) begin
					w.depth_in = ($urandom_range(3) == 0) ? 16'($urandom())
						: 16'($urandom_range(4095));
					w.pixel_col = 10'($urandom());
					w.pixel_row = 10'($urandom());
					w.frame_end_in = ($urandom_range(15) == 0);
					send_word(w, 0, '0);
				end
				in_valid <= 1'b0;
			end
		end

		waited = 0;
		while (pending_q.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (100) @(negedge clk);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("PASS tof_depth_gain_and_radial_correction_top");
		end else begin
			$display("FAIL tof_depth_gain_and_radial_correction_top");
		end
		$finish;
	end

endmodule
